// ===== design/sdpa_pkg.sv =====
// Shared constants and types for the degree-angle sine approximation pipeline.
`timescale 1ns / 1ps

package sdpa_pkg;

  localparam int NUM_STAGES = 8;

  localparam int CHUNK_BITS = 12;
  localparam int SUM_BITS   = 14;

  localparam logic [5:0]  MOD45       = 6'd45;
  localparam logic [12:0] MOD45_RECIP = 13'd5826;

  localparam logic [16:0] HALF_TURN   = 17'd46080;
  localparam logic [31:0] POLY_ADD_SC = 32'd1828454400;

  localparam int          DIV_SHIFT_BASE = 39;
  localparam logic [21:0] DIV_ODD        = 22'd2278125;
  localparam logic [31:0] DIV_RECIP      = 32'((64'd1 << 53) / 64'd2278125);

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
    logic [NUM_STAGES-1:0] vld;
  } pipe_ctrl_t;

endpackage

// ===== design/sdpa_chan_if.sv =====
// Valid/ready channel interfaces for angle beats in and sine beats out.
`timescale 1ns / 1ps

interface sdpa_in_if #(
  parameter int ANGLE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [ANGLE_WIDTH-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink (input valid, input angle, output ready);
endinterface

interface sdpa_out_if #(
  parameter int SINE_WIDTH = 18
);
  logic                         valid;
  logic                         ready;
  logic signed [SINE_WIDTH-1:0] sine;

  modport source (output valid, output sine, input ready);
  modport sink (input valid, input sine, output ready);
endinterface

// ===== design/sdpa_pipe_ctrl.sv =====
// Stage valid bits and per-stage load enables with bubble collapse.
`timescale 1ns / 1ps

module sdpa_pipe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_ready,
  output sdpa_pkg::pipe_ctrl_t ctrl
);
  import sdpa_pkg::*;

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] en;

  // A stage loads when it is empty or the stage after it moves on.
  always_comb begin
    en[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          vld_r[k] <= (k == 0) ? in_valid : vld_r[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  assign ctrl.en  = en;
  assign ctrl.vld = vld_r;

endmodule

// ===== design/sine_degrees_poly_approx.sv =====
// Top level: pipelined quartic sine approximation of an angle in degrees.
//
//   channel    direction  handshake                    payload
//   in_chan    in         in_chan.valid / .ready       angle, ANGLE_WIDTH bits, 1/256 degree
//   out_chan   out        out_chan.valid / .ready      sine, SINE_FRAC_BITS+2 bits, signed
//
// One beat per cycle in and out while the sink is ready; the path runs through eight register stages.
// Stage 0-2 fold the angle modulo 360 degrees, 3-4 form the polynomial, 5-7 divide
// by the constant through a reciprocal multiply and one correction step; 7 also negates.
// An empty stage loads even while a later one stalls, so bubbles close up.
// Reset (rst_n, synchronous) clears the valid bits only; the data registers are not reset.
`timescale 1ns / 1ps

module sine_degrees_poly_approx #(
  parameter int ANGLE_WIDTH    = 32,
  parameter int SINE_FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  sdpa_in_if.sink   in_chan,
  sdpa_out_if.source out_chan
);
  import sdpa_pkg::*;

  localparam int SINE_WIDTH = SINE_FRAC_BITS + 2;
  localparam int QW         = ANGLE_WIDTH - 11;
  localparam int NCH        = (QW + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int UW         = NCH * CHUNK_BITS;
  localparam logic [5:0] Q_WRAP = 6'((64'd1 << QW) % 64'd45);
  localparam int DSH        = DIV_SHIFT_BASE - SINE_FRAC_BITS;
  localparam int PW         = SINE_FRAC_BITS + 24;
  localparam logic [SINE_WIDTH-1:0] ONE_Q = SINE_WIDTH'(1) << SINE_FRAC_BITS;
  localparam logic [SINE_WIDTH-1:0] NEG_ONE_Q = SINE_WIDTH'(0) - ONE_Q;

  pipe_ctrl_t ctrl;

  sdpa_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .out_ready (out_chan.ready),
    .ctrl      (ctrl)
  );

  assign in_chan.ready  = ctrl.en[0];
  assign out_chan.valid = ctrl.vld[NUM_STAGES-1];

  // Stage 0: sum 12-bit chunks of floor(angle / 2048); 4096 is 1 modulo 45.
  logic [UW-1:0]       upad;
  logic [SUM_BITS-1:0] sum_nxt, sum_r;
  logic [10:0]         low0_r;
  logic                sign0_r;

  assign upad = UW'(in_chan.angle[ANGLE_WIDTH-1:11]);

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < NCH; i++) begin
      sum_nxt = sum_nxt + SUM_BITS'(upad[i*CHUNK_BITS +: CHUNK_BITS]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      sum_r   <= sum_nxt;
      low0_r  <= in_chan.angle[10:0];
      sign0_r <= in_chan.angle[ANGLE_WIDTH-1];
    end
  end

  // Stage 1: fold once more, estimate the quotient by 45.
  logic [12:0] x_nxt, x1_r;
  logic [25:0] mod_prod;
  logic [6:0]  q45_r;
  logic [10:0] low1_r;
  logic        sign1_r;

  assign x_nxt    = 13'(sum_r[11:0]) + 13'(sum_r[SUM_BITS-1:12]);
  assign mod_prod = 26'(x_nxt) * 26'(MOD45_RECIP);

  always_ff @(posedge clk) begin
    if (ctrl.en[1]) begin
      x1_r    <= x_nxt;
      q45_r   <= mod_prod[24:18];
      low1_r  <= low0_r;
      sign1_r <= sign0_r;
    end
  end

  // Stage 2: residue, floor correction for negative angles, half split.
  logic [5:0]  rem;
  logic [5:0]  rem_adj;
  logic [16:0] m_nxt;
  logic        odd_nxt;
  logic [15:0] t_nxt, t2_r;
  logic        odd2_r;

  assign rem = 6'(x1_r - 13'(q45_r) * 13'(MOD45));

  always_comb begin
    rem_adj = rem;
    if (sign1_r) begin
      if (rem >= Q_WRAP) begin
        rem_adj = rem - Q_WRAP;
      end else begin
        rem_adj = 6'(7'(rem) + 7'(MOD45) - 7'(Q_WRAP));
      end
    end
  end

  assign m_nxt   = {rem_adj, low1_r};
  assign odd_nxt = m_nxt >= HALF_TURN;
  assign t_nxt   = odd_nxt ? 16'(m_nxt - HALF_TURN) : 16'(m_nxt);

  always_ff @(posedge clk) begin
    if (ctrl.en[2]) begin
      t2_r   <= t_nxt;
      odd2_r <= odd_nxt;
    end
  end

  // Stage 3: r = t * (180 - t).
  logic [15:0] t_comp;
  logic [29:0] r_nxt, r3_r;
  logic        odd3_r;

  assign t_comp = 16'(HALF_TURN - 17'(t2_r));
  assign r_nxt  = 30'(32'(t2_r) * 32'(t_comp));

  always_ff @(posedge clk) begin
    if (ctrl.en[3]) begin
      r3_r   <= r_nxt;
      odd3_r <= odd2_r;
    end
  end

  // Stage 4: n = r * (27900 + r), scaled.
  logic [61:0] n_nxt, n4_r;
  logic        odd4_r;

  assign n_nxt = 62'(64'(r3_r) * 64'(POLY_ADD_SC + 32'(r3_r)));

  always_ff @(posedge clk) begin
    if (ctrl.en[4]) begin
      n4_r   <= n_nxt;
      odd4_r <= odd3_r;
    end
  end

  // Stage 5: quotient estimate, never above the true value, at most one below.
  logic [63:0]           q_prod;
  logic [SINE_WIDTH-1:0] qe5_r;
  logic [61:0]           n5_r;
  logic                  odd5_r;

  assign q_prod = 64'(n4_r[61:30]) * 64'(DIV_RECIP);

  always_ff @(posedge clk) begin
    if (ctrl.en[5]) begin
      qe5_r  <= q_prod[63:62-SINE_FRAC_BITS];
      n5_r   <= n4_r;
      odd5_r <= odd4_r;
    end
  end

  // Stage 6: bound for the next quotient step.
  logic [PW-1:0]         hi_nxt, hi6_r;
  logic [PW-1:0]         nsh6_r;
  logic [SINE_WIDTH-1:0] qe6_r;
  logic                  odd6_r;

  assign hi_nxt = (PW'(qe5_r) + PW'(1)) * PW'(DIV_ODD);

  always_ff @(posedge clk) begin
    if (ctrl.en[6]) begin
      hi6_r  <= hi_nxt;
      nsh6_r <= PW'(n5_r >> DSH);
      qe6_r  <= qe5_r;
      odd6_r <= odd5_r;
    end
  end

  // Stage 7: correct, negate in the odd half, hold for the sink.
  logic [SINE_WIDTH-1:0] q_fin;
  logic [SINE_WIDTH-1:0] sine_nxt, sine_r;

  assign q_fin    = (nsh6_r >= hi6_r) ? qe6_r + SINE_WIDTH'(1) : qe6_r;
  assign sine_nxt = odd6_r ? SINE_WIDTH'(0) - q_fin : q_fin;

  always_ff @(posedge clk) begin
    if (ctrl.en[7]) begin
      sine_r <= sine_nxt;
    end
  end

  assign out_chan.sine = sine_r;

`ifndef ASSERT_OFF
  a_half_range : assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.vld[2] |-> (t2_r < 16'(HALF_TURN)))
    else $error("half-period angle out of range");

  a_est_low : assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.vld[6] |-> (hi6_r - PW'(DIV_ODD) <= nsh6_r))
    else $error("quotient estimate above true quotient");

  a_est_high : assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.vld[6] |-> (nsh6_r < hi6_r + PW'(DIV_ODD)))
    else $error("quotient estimate more than one below");

  a_sine_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> ((!sine_r[SINE_WIDTH-1] && sine_r <= ONE_Q) ||
                        (sine_r[SINE_WIDTH-1] && sine_r >= NEG_ONE_Q)))
    else $error("sine beat outside [-1, 1]");
`endif

endmodule

// ===== dv/tb_sine_degrees_poly_approx.sv =====
// Testbench for the degree-angle sine approximation: directed table, random angles, checks.
`timescale 1ns / 1ps

module tb_sine_degrees_poly_approx;

  localparam int          ANGLE_W     = 32;
  localparam int          SINE_W      = 18;
  localparam int          RANDOM_ANGLES = 850;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          DRAIN_WAIT  = 16;
  localparam logic [63:0] TURN_UNITS  = 64'd92160;
  localparam logic [63:0] HALF_UNITS  = 64'd46080;
  localparam logic [63:0] POLY_OFFSET = 64'd27900 << 16;
  localparam logic [63:0] POLY_SCALE  = 64'd291600000;
  localparam int          SINE_ONE    = 65536;
  localparam int          DEG         = 256;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic                      typed;
    logic signed [SINE_W-1:0]  sine;
  } probe_t;

  localparam int NUM_PROBES = 22;

  probe_t probe_rows [0:NUM_PROBES-1] = '{
    '{32'sd0,                   1'b1, 18'sd0},
    '{32'sd23040,               1'b1, 18'(SINE_ONE)},
    '{32'sd46080,               1'b1, 18'sd0},
    '{32'sd69120,               1'b1, 18'(-SINE_ONE)},
    '{32'sd92160,               1'b1, 18'sd0},
    '{-32'sd23040,              1'b1, 18'(-SINE_ONE)},
    '{-32'sd46080,              1'b1, 18'sd0},
    '{-32'sd69120,              1'b1, 18'(SINE_ONE)},
    '{32'sd115200,              1'b1, 18'(SINE_ONE)},
    '{32'sd2147420160,          1'b1, 18'sd0},
    '{-32'sd2147420160,         1'b1, 18'sd0},
    '{32'sd2147351040,          1'b1, 18'(SINE_ONE)},
    '{-32'sd2147351040,         1'b1, 18'(-SINE_ONE)},
    '{32'sd1,                   1'b0, 18'sd0},
    '{-32'sd1,                  1'b0, 18'sd0},
    '{32'sh7fffffff,            1'b0, 18'sd0},
    '{32'sh80000000,            1'b0, 18'sd0},
    '{32'sd11520,               1'b0, 18'sd0},
    '{32'sd46079,               1'b0, 18'sd0},
    '{32'sd46081,               1'b0, 18'sd0},
    '{32'sd92159,               1'b0, 18'sd0},
    '{32'sh55555555,            1'b0, 18'sd0}
  };

  logic clk;
  logic rst_n;
  logic calm;
  int   cycles = 0;
  int   failures = 0;

  logic signed [SINE_W-1:0] sine_due [$];

  sdpa_in_if  #(.ANGLE_WIDTH(ANGLE_W)) in_ch ();
  sdpa_out_if #(.SINE_WIDTH(SINE_W))   out_ch ();

  sine_degrees_poly_approx #(
    .ANGLE_WIDTH   (ANGLE_W),
    .SINE_FRAC_BITS(16)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_ch),
    .out_chan(out_ch)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic signed [SINE_W-1:0] sine_of_angle(input logic signed [ANGLE_W-1:0] a);
    logic [63:0] mag;
    logic [63:0] turn;
    logic [63:0] t;
    logic [63:0] r;
    logic [63:0] n;
    logic [63:0] s;
    logic        odd;
    if (a[ANGLE_W-1]) begin
      mag  = {32'd0, ~a} + 64'd1;
      turn = mag % TURN_UNITS;
      if (turn != 64'd0) turn = TURN_UNITS - turn;
    end else begin
      turn = {32'd0, a} % TURN_UNITS;
    end
    odd = turn >= HALF_UNITS;
    t   = odd ? turn - HALF_UNITS : turn;
    r   = t * (HALF_UNITS - t);
    n   = r * (POLY_OFFSET + r);
    s   = (n >> 16) / POLY_SCALE;
    if (odd) s = -s;
    return s[SINE_W-1:0];
  endfunction

  task automatic send_angle(input logic signed [ANGLE_W-1:0] a,
                            input logic signed [SINE_W-1:0] want);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.angle <= a;
    do @(posedge clk); while (!in_ch.ready);
    sine_due.push_back(want);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sine_degrees_poly_approx regression: fail");
      $finish;
    end
  end

  // sink side: random back-pressure, check each beat against the oldest expectation
  initial begin
    int                       stall;
    logic signed [SINE_W-1:0] want;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (sine_due.size() == 0) begin
        $error("sine: no beat expected, got %0d", out_ch.sine);
        failures++;
      end else begin
        want = sine_due.pop_front();
        if (out_ch.sine !== want) begin
          $error("sine: expected %0d, got %0d", want, out_ch.sine);
          failures++;
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    logic signed [ANGLE_W-1:0] a;
    longint                    k;
    longint                    off;
    calm        = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.angle = '0;
    rst_n       = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < NUM_PROBES; i++) begin
      a = probe_rows[i].angle;
      send_angle(a, probe_rows[i].typed ? probe_rows[i].sine : sine_of_angle(a));
    end

    for (int i = 0; i < RANDOM_ANGLES; i++) begin
      if (i % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      if (i == RANDOM_ANGLES / 2) begin
        // hold off until the pipeline has emptied
        in_ch.valid <= 1'b0;
        while (sine_due.size() != 0) @(negedge clk);
      end
      case ($urandom_range(0, 3))
        0: a = $urandom;
        1: begin
          k   = $urandom_range(0, 92000);
          k   = k - 46000;
          off = $urandom_range(0, 600);
          a   = ANGLE_W'(k * 46080 + off - 300);
        end
        2: begin
          off = $urandom_range(0, 368640);
          a   = ANGLE_W'(off - 184320);
        end
        default: begin
          k = $urandom_range(0, 160);
          a = ANGLE_W'((k - 80) * 90 * DEG);
        end
      endcase
      send_angle(a, sine_of_angle(a));
    end
    in_ch.valid <= 1'b0;
    calm = 1'b0;

    while (sine_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (failures == 0) begin
      $display("sine_degrees_poly_approx regression: pass");
    end else begin
      $display("sine_degrees_poly_approx regression: fail");
    end
    $finish;
  end

endmodule
